[rtl/dts_pkg.sv]
// Shared types, codes, constants and the sine table of the DDS tone sequencer.
`timescale 1ns / 1ps

package dts_pkg;

    // Field widths of the request and result channels.
    localparam int MODE_W      = 2;
    localparam int FREQ_W      = 15;
    localparam int DUR_W       = 16;
    localparam int SLOT_W      = 4;
    localparam int DAC_W       = 16;
    localparam int PHASE_W     = 32;
    localparam int SINE_W      = 28;
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_IDX_W  = 8;
    localparam int SLOT_COUNT  = 16;

    // Configuration port.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MUSIC_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TUNE_SELECT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH  = 2'd2;

    // Request modes; the fourth code is ignored.
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EFFECT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TUNE_WR = 2'd2;

    localparam logic [DUR_W-1:0] NOTE_LEN_RESET = 16'd4000;
    localparam logic [DAC_W-1:0] DAC_CHAN_B     = 16'hB000;
    localparam logic [DAC_W-1:0] DAC_OFFSET     = 16'd2048;
    localparam logic [15:0]      GAIN_EFFECT    = 16'd32768;
    localparam logic [15:0]      GAIN_TUNE      = 16'd9830;
    localparam int               GAIN_SHIFT     = 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_FIX,
        ST_PHASE,
        ST_SINE,
        ST_GAIN,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              playing;
        logic [FREQ_W-1:0] frequency;
        logic [DUR_W-1:0]  duration;
        logic              tune;
        logic [SLOT_W-1:0] slot;
    } in_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;
        logic est_en;
        logic fix_en;
        logic phase_en;
        logic sine_en;
        logic gain_en;
        logic out_load;
    } dts_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic tick_sounds;
        logic out_free;
    } dts_stat_t;

    // Sine table generation, evaluated at elaboration only.
    localparam longint unsigned PI_Q60   = 64'h3243_F6A8_885A_308D;
    localparam longint unsigned AMP_Q15  = 64'd67076096;
    localparam longint unsigned SINE_DEN = 64'd1000 * 64'(SINE_ENTRIES);

    typedef longint unsigned taylor_div_t [13];
    localparam taylor_div_t TAYLOR_DIV = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_ENTRIES];

    // Q60 product of two operands below 8.
    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        longint unsigned ah;
        longint unsigned al;
        longint unsigned bh;
        longint unsigned bl;
        ah = a >> 32;
        al = a & 64'hFFFF_FFFF;
        bh = b >> 32;
        bl = b & 64'hFFFF_FFFF;
        return ((ah * bh) << 4) + ((ah * bl) >> 28) + ((al * bh) >> 28) + ((al * bl) >> 60);
    endfunction

    // One table entry: 2047 * 32768 * sin(i * 6.283 / 256), truncated.
    function automatic logic signed [SINE_W-1:0] sine_sample(int unsigned i);
        longint unsigned q;
        longint unsigned r;
        longint unsigned frac;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned sh;
        longint unsigned sl;
        longint unsigned mag;
        logic signed [SINE_W-1:0] m28;
        logic neg;
        q    = 64'(i) * 64'd6283;
        r    = q % SINE_DEN;
        frac = 64'd0;
        neg  = 1'b0;
        for (int k = 0; k < 60; k++) begin
            r    = r << 1;
            frac = frac << 1;
            if (r >= SINE_DEN) begin
                r    = r - SINE_DEN;
                frac = frac | 64'd1;
            end
        end
        x = ((q / SINE_DEN) << 60) + frac;
        if (x >= PI_Q60) begin
            x   = x - PI_Q60;
            neg = 1'b1;
        end
        if (x > (PI_Q60 >> 1)) begin
            x = PI_Q60 - x;
        end
        x2   = qmul(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 13; k++) begin
            term = qmul(term, x2) / TAYLOR_DIV[k-1];
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sh  = sum >> 30;
        sl  = sum & 64'h3FFF_FFFF;
        mag = (sh * AMP_Q15 + ((sl * AMP_Q15) >> 30)) >> 30;
        m28 = SINE_W'(mag);
        return neg ? -m28 : m28;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            rom[i] = sine_sample(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[rtl/dts_ifs.sv]
// Request and result channel interfaces of the DDS tone sequencer.
`timescale 1ns / 1ps

interface dts_in_if;
    import dts_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              playing;
    logic [FREQ_W-1:0] frequency;
    logic [DUR_W-1:0]  duration;
    logic              tune;
    logic [SLOT_W-1:0] slot;

    modport source (
        output valid, mode, playing, frequency, duration, tune, slot,
        input  ready
    );
    modport sink (
        input  valid, mode, playing, frequency, duration, tune, slot,
        output ready
    );
endinterface

interface dts_out_if;
    import dts_pkg::*;

    logic             valid;
    logic             ready;
    logic [DAC_W-1:0] dac_word;
    logic             effect_active;

    modport source (
        output valid, dac_word, effect_active,
        input  ready
    );
    modport sink (
        input  valid, dac_word, effect_active,
        output ready
    );
endinterface

[rtl/dts_ctrl.sv]
// Sequencing state machine of the DDS tone sequencer.
`timescale 1ns / 1ps

module dts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dts_pkg::dts_stat_t stat,
    output dts_pkg::dts_cmd_t  cmd
);
    import dts_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.tick_sounds) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:  state_next = ST_FIX;
            ST_FIX:   state_next = ST_PHASE;
            ST_PHASE: state_next = ST_SINE;
            ST_SINE:  state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_STEP:  cmd.est_en   = 1'b1;
            ST_FIX:   cmd.fix_en   = 1'b1;
            ST_PHASE: cmd.phase_en = 1'b1;
            ST_SINE:  cmd.sine_en  = 1'b1;
            ST_GAIN:  cmd.gain_en  = 1'b1;
            ST_OUT:   cmd.out_load = stat.out_free;
            default:  cmd          = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && stat.tick_sounds) |=> (state_reg == ST_STEP))
        else $error("sounding tick did not start the datapath sequence");

    a_step_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |=> (state_reg == ST_FIX))
        else $error("phase step sequence broken");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && !stat.out_free) |=> (state_reg == ST_OUT))
        else $error("result left before the output register was free");
`endif

endmodule

[rtl/dts_datapath.sv]
// Datapath of the DDS tone sequencer: note state, phase step, phase, sine and gain.
`timescale 1ns / 1ps

module dts_datapath #(
    parameter int TUNE_LEN    = 16,
    parameter int SAMPLE_RATE = 40000
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  dts_pkg::in_item_t                item,
    input  dts_pkg::dts_cmd_t                cmd,
    output dts_pkg::dts_stat_t               stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dts_pkg::DAC_W-1:0]        dac_word,
    output logic                             effect_active
);
    import dts_pkg::*;

    // Only the first sixteen slots of a tune can be written; the rest read as rests.
    localparam int STORE_LEN  = (TUNE_LEN < SLOT_COUNT) ? TUNE_LEN : SLOT_COUNT;
    localparam int SIW        = $clog2(STORE_LEN);
    localparam int POS_W      = $clog2(TUNE_LEN);
    localparam int STEP_SHIFT = PHASE_W + FREQ_W;
    localparam longint unsigned RECIP = (64'd1 << STEP_SHIFT) / 64'(SAMPLE_RATE);
    localparam int RECIP_W    = $clog2(RECIP + 64'd1);
    localparam int SR_W       = $clog2(SAMPLE_RATE + 1);
    localparam int REM_W      = SR_W + 1;
    localparam int PROD_W     = SINE_W + 17;
    localparam logic [RECIP_W-1:0]  RECIP_L   = RECIP_W'(RECIP);
    localparam logic [REM_W-1:0]    SR_L      = REM_W'(SAMPLE_RATE);
    localparam logic [POS_W-1:0]    POS_LAST  = POS_W'(TUNE_LEN - 1);
    localparam logic [SLOT_W:0]     TUNE_LIM  = (SLOT_W+1)'(TUNE_LEN > SLOT_COUNT ?
                                                            SLOT_COUNT : TUNE_LEN);

    // Configuration registers.
    logic              music_enable_reg;
    logic              tune_select_reg;
    logic [DUR_W-1:0]  note_length_reg;

    // Note state.
    logic              effect_on_reg;
    logic [FREQ_W-1:0] effect_freq_reg;
    logic [DUR_W-1:0]  effect_left_reg;
    logic [FREQ_W-1:0] notes_reg [2][STORE_LEN];
    logic [POS_W-1:0]  tune_pos_reg [2];
    logic [DUR_W-1:0]  tune_left_reg [2];

    // Tick pipeline.
    logic [FREQ_W-1:0]        freq_reg;
    logic                     eff_reg;
    logic [RECIP_W-1:0]       est_reg;
    logic                     fix_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic signed [SINE_W-1:0] sine_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     out_valid_reg;
    logic [DAC_W-1:0]         dac_word_reg;
    logic                     effect_active_reg;

    logic [FREQ_W-1:0]          tune_freq;
    logic [POS_W-1:0]           cur_pos;
    logic [FREQ_W+RECIP_W-1:0]  est_prod;
    logic [REM_W-1:0]           fix_prod;
    logic [REM_W-1:0]           rem;
    logic [RECIP_W:0]           step_full;
    logic [PHASE_W-1:0]         phase_next;
    logic signed [16:0]         gain;
    logic signed [PROD_W-1:0]   prod_next;
    logic [DAC_W-1:0]           scaled;
    logic [DAC_W-1:0]           dac_word_next;
    logic                       slot_ok;

    assign cur_pos = tune_pos_reg[tune_select_reg];

    always_comb begin
        tune_freq = '0;
        if (POS_W'(STORE_LEN - 1) >= cur_pos) begin
            tune_freq = notes_reg[tune_select_reg][cur_pos[SIW-1:0]];
        end
    end

    assign slot_ok = ({1'b0, item.slot} < TUNE_LIM);

    assign stat.tick_sounds = (item.mode == MODE_TICK) && music_enable_reg
                              && (effect_on_reg || item.playing);
    assign stat.out_free    = !out_valid_reg || out_ready;

    // Step = floor(freq * 2^32 / rate): reciprocal estimate, then one correction.
    assign est_prod   = {{RECIP_W{1'b0}}, freq_reg} * {{FREQ_W{1'b0}}, RECIP_L};
    assign fix_prod   = est_reg[REM_W-1:0] * SR_L;
    assign rem        = '0 - fix_prod;
    assign step_full  = {1'b0, est_reg} + {{RECIP_W{1'b0}}, fix_reg};
    assign phase_next = phase_reg + PHASE_W'(step_full);

    assign gain       = eff_reg ? $signed({1'b0, GAIN_EFFECT}) : $signed({1'b0, GAIN_TUNE});
    assign prod_next  = PROD_W'(gain * sine_reg);
    assign scaled     = DAC_W'(prod_reg >>> GAIN_SHIFT);
    assign dac_word_next = DAC_CHAN_B | (scaled + DAC_OFFSET);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            music_enable_reg <= 1'b1;
            tune_select_reg  <= 1'b0;
            note_length_reg  <= NOTE_LEN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MUSIC_ENABLE: music_enable_reg <= cfg_data[0];
                REG_TUNE_SELECT:  tune_select_reg  <= cfg_data[0];
                REG_NOTE_LENGTH:  note_length_reg  <= cfg_data[DUR_W-1:0];
                default:          music_enable_reg <= music_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            effect_on_reg   <= 1'b0;
            effect_freq_reg <= '0;
            effect_left_reg <= '0;
            for (int t = 0; t < 2; t++) begin
                tune_pos_reg[t]  <= '0;
                tune_left_reg[t] <= NOTE_LEN_RESET;
                for (int s = 0; s < STORE_LEN; s++) begin
                    notes_reg[t][s] <= '0;
                end
            end
        end else if (cmd.take) begin
            case (item.mode)
                MODE_EFFECT:
                begin
                    effect_on_reg   <= 1'b1;
                    effect_freq_reg <= item.frequency;
                    effect_left_reg <= item.duration;
                end
                MODE_TUNE_WR:
                begin
                    if (slot_ok) begin
                        notes_reg[item.tune][item.slot[SIW-1:0]] <= item.frequency;
                    end
                end
                MODE_TICK:
                begin
                    if (stat.tick_sounds) begin
                        if (effect_on_reg) begin
                            effect_left_reg <= effect_left_reg - 1'b1;
                            if (effect_left_reg == DUR_W'(1)) begin
                                effect_on_reg <= 1'b0;
                            end
                        end
                        for (int t = 0; t < 2; t++) begin
                            if (tune_left_reg[t] == DUR_W'(1)) begin
                                tune_left_reg[t] <= note_length_reg;
                                tune_pos_reg[t]  <= (tune_pos_reg[t] == POS_LAST)
                                                    ? '0 : tune_pos_reg[t] + 1'b1;
                            end else begin
                                tune_left_reg[t] <= tune_left_reg[t] - 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    effect_on_reg <= effect_on_reg;
                end
            endcase
        end
    end

    // Tick pipeline payload.
    always_ff @(posedge clk) begin
        if (cmd.take && stat.tick_sounds) begin
            eff_reg  <= effect_on_reg;
            freq_reg <= effect_on_reg ? effect_freq_reg : tune_freq;
        end
        if (cmd.est_en) begin
            est_reg <= est_prod[FREQ_W+RECIP_W-1:FREQ_W];
        end
        if (cmd.fix_en) begin
            fix_reg <= (rem >= SR_L);
        end
        if (cmd.sine_en) begin
            sine_reg <= SINE_ROM[phase_reg[PHASE_W-1 -: SINE_IDX_W]];
        end
        if (cmd.gain_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load) begin
            dac_word_reg      <= dac_word_next;
            effect_active_reg <= eff_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.phase_en) begin
                phase_reg <= phase_next;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign dac_word      = dac_word_reg;
    assign effect_active = effect_active_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while holding an untaken result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_valid_reg && (dac_word_reg[DAC_W-1 -: 4] == 4'hB)))
        else $error("loaded result not presented as a channel B word");

    a_effect_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(effect_on_reg) |-> $past(cmd.take && item.mode == MODE_TICK))
        else $error("effect note ended outside a sounding tick");
`endif

endmodule

[rtl/dts_tone_sequencer.sv]
// Top level of the DDS tone sequencer: channels, configuration port, controller and datapath.
//
//   channel   | direction | handshake     | payload
//   ----------+-----------+---------------+-----------------------------------------------
//   command   | in        | valid/ready   | mode, playing, frequency, duration, tune, slot
//   sample    | out       | valid/ready   | dac_word, effect_active
//   cfg       | in        | cfg_we only   | cfg_index, cfg_data
//
// A command or a skipped tick is taken in the idle state and starts no further steps. A
// sounding tick walks the controller through step estimate, step correction, phase add,
// sine table read, gain multiply and output load before its result. All control state and
// note state clear on rst_n low, asynchronously; the configuration registers return to their
// defaults. A result that is not taken holds the output register; the block still takes the
// next request, and a later tick waits in its last step until the output register is free.
`timescale 1ns / 1ps

module dds_tone_sequencer #(
    parameter int TUNE_LEN    = 16,
    parameter int SAMPLE_RATE = 40000
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dts_pkg::CFG_DATA_W-1:0] cfg_data,
    dts_in_if.sink                         command,
    dts_out_if.source                      sample
);
    import dts_pkg::*;

    in_item_t  item;
    dts_cmd_t  cmd;
    dts_stat_t stat;

    // Gather the request payload into one word for the datapath.
    assign item.mode      = command.mode;
    assign item.playing   = command.playing;
    assign item.frequency = command.frequency;
    assign item.duration  = command.duration;
    assign item.tune      = command.tune;
    assign item.slot      = command.slot;

    // The controller owns the request handshake and steps the datapath one stage per cycle,
    // save while the output register is full; it sees payload bits only through the status word.
    dts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (command.valid),
        .in_ready (command.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the effect and tune note state,
    // the phase accumulator, the pipeline of the sample computation and the result
    // register that drives the sample channel.
    dts_datapath #(
        .TUNE_LEN    (TUNE_LEN),
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item          (item),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (sample.valid),
        .out_ready     (sample.ready),
        .dac_word      (sample.dac_word),
        .effect_active (sample.effect_active)
    );

endmodule

[tb/dds_tone_sequencer_tb.sv]
// Self-checking testbench of the DDS tone sequencer: predicts every DAC sample and compares it.
`timescale 1ns / 1ps

module dds_tone_sequencer_tb;
    import dts_pkg::*;

    // Block configuration used for the instance and for the prediction.
    localparam int TONE_SLOTS = 16;
    localparam int TICK_RATE  = 40000;

    // Run control.
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    // A margin for the block to settle before a register write or the final verdict.
    localparam int DRAIN_CYCLES = 12;
    // Length of the stretch in which the sample sink refuses everything.
    localparam int HOLD_CYCLES  = 400;
    // Cycles without any handshake before the run is declared hung. The longest correct
    // quiet stretch is the hold above plus a handful of drain cycles.
    localparam int STALL_LIMIT  = 4000;

    // Codes that the package does not name: the fourth mode and the fourth register index.
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    // Sample arithmetic.
    localparam int               EFFECT_GAIN = 32768;  // 1.0 in Q15
    localparam int               TUNE_GAIN   = 9830;   // 0.3 in Q15
    localparam logic [15:0]      DAC_CMD     = 16'hB000;
    localparam int               MID_CODE    = 2048;
    localparam logic [15:0]      NOTE_LEN_RST = 16'd4000;

    // Sine table construction in Q60 fixed point.
    localparam longint unsigned ANGLE_PI  = 64'h3243_F6A8_885A_308D;
    localparam longint unsigned SINE_PEAK = 64'd67076096;  // 2047 * 32768
    localparam longint unsigned ANGLE_DEN = 64'd256000;    // 1000 * table entries
    localparam int              SINE_SIZE = 256;

    typedef struct {
        logic [DAC_W-1:0] dac_word;
        logic             effect_active;
    } dac_sample_t;

    // The class keeps its own copy of the tone engine state and the configuration.
    // Every accepted request runs through note_request; every sounding tick leaves one
    // expected sample in the queue, which check_sample compares in order.
    class tone_scoreboard;
        bit               music_on;
        bit               tune_sel;
        bit [15:0]        note_len;
        bit [31:0]        phase_acc;
        bit               effect_on;
        bit [FREQ_W-1:0]  effect_freq;
        bit [15:0]        effect_left;
        bit [FREQ_W-1:0]  tune_freq [2][TONE_SLOTS];
        bit [3:0]         tune_pos [2];
        bit [15:0]        tune_left [2];
        int               sine_table [SINE_SIZE];
        dac_sample_t      expected_samples [$];
        int               mismatches;

        function new();
            music_on    = 1'b1;
            tune_sel    = 1'b0;
            note_len    = NOTE_LEN_RST;
            phase_acc   = '0;
            effect_on   = 1'b0;
            effect_freq = '0;
            effect_left = '0;
            mismatches  = 0;
            for (int t = 0; t < 2; t++)
            begin
                tune_pos[t]  = '0;
                tune_left[t] = NOTE_LEN_RST;
                for (int s = 0; s < TONE_SLOTS; s++)
                begin
                    tune_freq[t][s] = '0;
                end
            end
            for (int i = 0; i < SINE_SIZE; i++)
            begin
                sine_table[i] = sine_entry(i);
            end
        endfunction

        // Product of two Q60 values below 8, truncated the same way term by term.
        function longint unsigned q60_mul(longint unsigned a, longint unsigned b);
            longint unsigned a_hi;
            longint unsigned a_lo;
            longint unsigned b_hi;
            longint unsigned b_lo;
            a_hi = a >> 32;
            a_lo = a & 64'hFFFF_FFFF;
            b_hi = b >> 32;
            b_lo = b & 64'hFFFF_FFFF;
            return ((a_hi * b_hi) << 4) + ((a_hi * b_lo) >> 28) + ((a_lo * b_hi) >> 28)
                   + ((a_lo * b_lo) >> 60);
        endfunction

        // trunc(2047 * 32768 * sin(idx * 6.283 / 256)) by a Taylor series in Q60.
        function int sine_entry(int unsigned idx);
            longint unsigned num;
            longint unsigned rem;
            longint unsigned frac;
            longint unsigned ang;
            longint unsigned ang_sq;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned divisor;
            longint unsigned hi;
            longint unsigned lo;
            longint unsigned mag;
            bit              negative;
            num      = 64'(idx) * 64'd6283;
            rem      = num % ANGLE_DEN;
            frac     = '0;
            negative = 1'b0;
            // Long division gives 60 fraction bits of the angle.
            for (int n = 0; n < 60; n++)
            begin
                rem  = rem << 1;
                frac = frac << 1;
                if (rem >= ANGLE_DEN)
                begin
                    rem  = rem - ANGLE_DEN;
                    frac = frac | 64'd1;
                end
            end
            ang = ((num / ANGLE_DEN) << 60) + frac;
            // Fold the angle into the first quadrant and remember the sign.
            if (ang >= ANGLE_PI)
            begin
                ang      = ang - ANGLE_PI;
                negative = 1'b1;
            end
            if (ang > (ANGLE_PI >> 1))
            begin
                ang = ANGLE_PI - ang;
            end
            ang_sq = q60_mul(ang, ang);
            term   = ang;
            acc    = ang;
            for (int k = 1; k <= 13; k++)
            begin
                divisor = (2 * k) * (2 * k + 1);
                term    = q60_mul(term, ang_sq) / divisor;
                if (k % 2 == 1)
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
            hi  = acc >> 30;
            lo  = acc & 64'h3FFF_FFFF;
            mag = (hi * SINE_PEAK + ((lo * SINE_PEAK) >> 30)) >> 30;
            return negative ? -int'(mag) : int'(mag);
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MUSIC_ENABLE: music_on = value[0];
                REG_TUNE_SELECT:  tune_sel = value[0];
                REG_NOTE_LENGTH:  note_len = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_request(in_item_t req);
            longint unsigned  step;
            longint signed    product;
            longint signed    scaled;
            bit [FREQ_W-1:0]  freq;
            int               gain;
            dac_sample_t      smp;
            case (req.mode)
                MODE_EFFECT:
                begin
                    effect_on   = 1'b1;
                    effect_freq = req.frequency;
                    effect_left = req.duration;
                end
                MODE_TUNE_WR:
                begin
                    tune_freq[req.tune][req.slot] = req.frequency;
                end
                MODE_TICK:
                begin
                    // A tick sounds only with music on and either an effect note or play.
                    if (music_on && (effect_on || req.playing))
                    begin
                        if (effect_on)
                        begin
                            freq = effect_freq;
                            gain = EFFECT_GAIN;
                        end
                        else
                        begin
                            freq = tune_freq[tune_sel][tune_pos[tune_sel]];
                            gain = TUNE_GAIN;
                        end
                        step      = {17'd0, freq, 32'd0} / TICK_RATE;
                        phase_acc = phase_acc + step[31:0];
                        product   = longint'(gain) * longint'(sine_table[phase_acc[31:24]]);
                        // Arithmetic shift floors toward minus infinity, as the DAC path does.
                        scaled    = product >>> 30;
                        smp.dac_word      = DAC_CMD | 16'(scaled + MID_CODE);
                        smp.effect_active = effect_on;
                        expected_samples.push_back(smp);
                        if (effect_on)
                        begin
                            effect_left = effect_left - 16'd1;
                            if (effect_left == 16'd0)
                            begin
                                effect_on = 1'b0;
                            end
                        end
                        // Both tunes run, sounding or not; a 4-bit position wraps at 16.
                        for (int t = 0; t < 2; t++)
                        begin
                            tune_left[t] = tune_left[t] - 16'd1;
                            if (tune_left[t] == 16'd0)
                            begin
                                tune_left[t] = note_len;
                                tune_pos[t]  = tune_pos[t] + 4'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        function void check_sample(logic [DAC_W-1:0] dac, logic eff);
            dac_sample_t want;
            if (expected_samples.size() == 0)
            begin
                report($sformatf("unexpected sample dac_word=%h effect_active=%b", dac, eff));
            end
            else
            begin
                want = expected_samples.pop_front();
                if (want.dac_word !== dac || want.effect_active !== eff)
                begin
                    report($sformatf({"sample mismatch: expected dac_word=%h effect_active=%b,",
                                      " got dac_word=%h effect_active=%b"},
                                     want.dac_word, want.effect_active, dac, eff));
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  hold_off;
    int                    send_idle;
    int                    recv_idle;
    tone_scoreboard        dac_model;

    dts_in_if  cmd_if ();
    dts_out_if smp_if ();

    dds_tone_sequencer #(
        .TUNE_LEN    (TONE_SLOTS),
        .SAMPLE_RATE (TICK_RATE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (cmd_if),
        .sample    (smp_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Request builders for the directed part. Fields a mode does not use stay zero here;
    // the random part fills them with noise.
    function automatic in_item_t tick_req(input logic playing);
        in_item_t req;
        req         = '0;
        req.mode    = MODE_TICK;
        req.playing = playing;
        return req;
    endfunction

    function automatic in_item_t effect_req(input logic [FREQ_W-1:0] freq,
                                            input logic [DUR_W-1:0] dur);
        in_item_t req;
        req           = '0;
        req.mode      = MODE_EFFECT;
        req.frequency = freq;
        req.duration  = dur;
        return req;
    endfunction

    function automatic in_item_t tune_req(input logic tune, input logic [SLOT_W-1:0] slot,
                                          input logic [FREQ_W-1:0] freq);
        in_item_t req;
        req           = '0;
        req.mode      = MODE_TUNE_WR;
        req.tune      = tune;
        req.slot      = slot;
        req.frequency = freq;
        return req;
    endfunction

    // Mostly ticks, most of them while playing, so the tunes keep stepping; effect notes
    // are short as a rule so that they end and hand back to the tune, but now and then
    // one gets a full random length and holds until the next effect replaces it.
    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        req.mode      = MODE_TICK;
        req.playing   = 1'($urandom);
        req.frequency = FREQ_W'($urandom);
        req.duration  = DUR_W'($urandom);
        req.tune      = 1'($urandom);
        req.slot      = SLOT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            req.mode    = MODE_TICK;
            req.playing = ($urandom_range(9) != 0);
        end
        else if (pick < 78)
        begin
            req.mode = MODE_EFFECT;
            if ($urandom_range(3) != 0)
            begin
                req.duration = DUR_W'($urandom_range(24, 1));
            end
        end
        else if (pick < 97)
        begin
            req.mode = MODE_TUNE_WR;
        end
        else
        begin
            req.mode = MODE_UNUSED;
        end
        // Rests are frequent enough in music to deserve their own share.
        if ($urandom_range(7) == 0)
        begin
            req.frequency = '0;
        end
        return req;
    endfunction

    // Offer one request, idling first at the sender's current rate, and hand it to the
    // scoreboard at the edge where it is taken. Valid stays high between back-to-back
    // requests, so it gets a single assignment per edge.
    task automatic send_request(input in_item_t req);
        if ($urandom_range(99) < send_idle)
        begin
            cmd_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.mode      <= req.mode;
        cmd_if.playing   <= req.playing;
        cmd_if.frequency <= req.frequency;
        cmd_if.duration  <= req.duration;
        cmd_if.tune      <= req.tune;
        cmd_if.slot      <= req.slot;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        dac_model.note_request(req);
    endtask

    // Stop offering, let every expected sample come out and give the block time to finish
    // any request that produces no sample.
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (dac_model.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Registers change only while the block is idle.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        dac_model.apply_register(idx, value);
    endtask

    // Random requests until the given number of requests that the block acts on is sent.
    task automatic run_random(input int count);
        in_item_t req;
        int       sent;
        sent = 0;
        while (sent < count)
        begin
            req = random_request();
            send_request(req);
            if (req.mode != MODE_UNUSED)
            begin
                sent++;
            end
        end
    endtask

    // Sample sink: checks every sample taken, then picks ready for the next edge. During
    // the hold the sink refuses everything so the block backs up into its command input.
    always @(posedge clk)
    begin
        if (rst_n && smp_if.valid && smp_if.ready)
        begin
            dac_model.check_sample(smp_if.dac_word, smp_if.effect_active);
        end
        if (hold_off)
        begin
            smp_if.ready <= 1'b0;
        end
        else
        begin
            smp_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (smp_if.valid && smp_if.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        in_item_t odd_req;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        hold_off         = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.mode      = '0;
        cmd_if.playing   = 1'b0;
        cmd_if.frequency = '0;
        cmd_if.duration  = '0;
        cmd_if.tune      = 1'b0;
        cmd_if.slot      = '0;
        smp_if.ready     = 1'b0;
        // First the sender idles a quarter of the time and the sink about half of it.
        send_idle        = 25;
        recv_idle        = 48;
        dac_model        = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset configuration. A tick with no effect note while
        // not playing is skipped.
        send_request(tick_req(1'b0));
        // Tune tables: a rest, a plain note, the largest frequency the field holds, and
        // notes at both ends of the table.
        send_request(tune_req(1'b0, 4'd0, 15'd0));
        send_request(tune_req(1'b0, 4'd1, 15'd440));
        send_request(tune_req(1'b0, 4'd15, 15'h7FFF));
        send_request(tune_req(1'b1, 4'd0, 15'd20000));
        send_request(tune_req(1'b1, 4'd15, 15'd1));
        // The tune sounds a rest at first.
        send_request(tick_req(1'b1));
        // A one-tick effect at the top frequency sounds even when not playing, then ends.
        send_request(effect_req(15'h7FFF, 16'd1));
        send_request(tick_req(1'b0));
        send_request(tick_req(1'b0));
        // An effect rest over three ticks, then the tune again.
        send_request(effect_req(15'd0, 16'd3));
        send_request(tick_req(1'b1));
        send_request(tick_req(1'b1));
        send_request(tick_req(1'b1));
        send_request(tick_req(1'b1));
        // A zero duration wraps to a very long note; a new effect replaces it.
        send_request(effect_req(15'd1000, 16'd0));
        send_request(tick_req(1'b0));
        send_request(effect_req(15'd20000, 16'd2));
        send_request(tick_req(1'b0));
        send_request(tick_req(1'b0));
        // The unused mode is ignored.
        odd_req      = tick_req(1'b1);
        odd_req.mode = MODE_UNUSED;
        send_request(odd_req);
        send_request(tick_req(1'b1));

        // The other tune.
        set_register(REG_TUNE_SELECT, 16'd1);
        send_request(tick_req(1'b1));
        // With music off every tick is skipped, even one with an effect note waiting.
        set_register(REG_MUSIC_ENABLE, 16'd0);
        send_request(tick_req(1'b1));
        send_request(effect_req(15'd500, 16'd1));
        send_request(tick_req(1'b0));
        set_register(REG_MUSIC_ENABLE, 16'd1);
        send_request(tick_req(1'b0));
        send_request(tick_req(1'b0));

        // The shortest note length. The tune countdowns still hold their reset load, so
        // the new length only matters once a countdown reloads.
        set_register(REG_NOTE_LENGTH, 16'd1);
        run_random(300);

        // Idling the other way round. Music off with the longest note length: the random
        // requests still edit the tables and the effect note, but no tick sounds.
        send_idle = 48;
        recv_idle <= 25;
        set_register(REG_TUNE_SELECT, 16'd0);
        set_register(REG_NOTE_LENGTH, 16'hFFFF);
        set_register(REG_MUSIC_ENABLE, 16'd0);
        run_random(40);
        set_register(REG_MUSIC_ENABLE, 16'd1);
        set_register(REG_NOTE_LENGTH, 16'd5);
        run_random(300);

        // No idling at all, a note length of zero that wraps to the longest one, and a
        // write to the register index that does not exist. The sink holds off for a long
        // stretch at the start while requests keep coming.
        send_idle = 0;
        recv_idle <= 0;
        set_register(REG_TUNE_SELECT, 16'd1);
        set_register(REG_NOTE_LENGTH, 16'd0);
        set_register(REG_UNUSED, CFG_DATA_W'($urandom));
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        run_random(300);

        wait_idle();
        if (dac_model.mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
